// ===== rtl/csrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN speed rescale gateway package
// Shared types, register map codes and arithmetic constants.
// ----------------------------------------------------------------------------
package csrg_pkg;

	// Register indexes on the configuration port (byte address / 4)
	localparam logic [1:0] REG_SPEED_ID_A    = 2'd0;
	localparam logic [1:0] REG_SPEED_ID_B    = 2'd1;
	localparam logic [1:0] REG_SCALE_PERCENT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [10:0] SPEED_ID_A_RST    = 11'h214;
	localparam logic [10:0] SPEED_ID_B_RST    = 11'h215;
	localparam logic [7:0]  SCALE_PERCENT_RST = 8'd110;

	// Speed encoding: 200 units per high byte, low byte in 1/128 steps of 100
	localparam logic [7:0] STEP_UNITS = 8'd200;
	localparam logic [6:0] PCT_DEN    = 7'd100;

	// Saturation threshold: q above 255 means scaled speed of 256*200 or more
	localparam logic [16:0] SAT_LIMIT = 17'd51200;
	localparam logic [7:0]  Q_SAT     = 8'd255;
	localparam logic [7:0]  R_SAT     = 8'd199;

	// Reciprocals for exact division by constants over the value ranges used
	// floor(p/100)   = (p * RECIP_100_31) >> 31 for p < 2^24
	localparam logic [24:0] RECIP_100_31 = 25'd21474837;
	// floor(s/200)   = (s * RECIP_200_24) >> 24 for s < 51200
	localparam logic [16:0] RECIP_200_24 = 17'd83887;
	// floor(x/100)   = (x * RECIP_100_22) >> 22 for x < 25600
	localparam logic [15:0] RECIP_100_22 = 16'd41944;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [10:0] speed_id_a;
		logic [10:0] speed_id_b;
		logic [7:0]  scale_percent;
	} cfg_t;

endpackage

// ===== rtl/csrg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN speed rescale gateway channels
// Valid/ready channels for received frames and forwarded frames.
// ----------------------------------------------------------------------------

// Received frame channel
interface csrg_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [10:0] frame_id;
	logic [63:0] payload;
	logic        tx_space;

	modport source (output valid, output op, output frame_id, output payload,
		output tx_space, input ready);
	modport sink (input valid, input op, input frame_id, input payload,
		input tx_space, output ready);
endinterface

// Forwarded frame channel
interface csrg_out_if;
	logic        valid;
	logic        ready;
	logic        dest_bus;
	logic [10:0] out_id;
	logic [63:0] out_payload;
	logic        watchdog_kick;

	modport source (output valid, output dest_bus, output out_id, output out_payload,
		output watchdog_kick, input ready);
	modport sink (input valid, input dest_bus, input out_id, input out_payload,
		input watchdog_kick, output ready);
endinterface

// ===== rtl/csrg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN speed rescale gateway configuration registers
// APB-style register file holding the two speed identifiers and the scale.
// ----------------------------------------------------------------------------
module csrg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output csrg_pkg::cfg_t cfg
);
	import csrg_pkg::*;

	logic [10:0] speed_id_a_q;
	logic [10:0] speed_id_b_q;
	logic [7:0]  scale_percent_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_id_a_q    <= SPEED_ID_A_RST;
			speed_id_b_q    <= SPEED_ID_B_RST;
			scale_percent_q <= SCALE_PERCENT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SPEED_ID_A:    speed_id_a_q    <= pwdata[10:0];
				REG_SPEED_ID_B:    speed_id_b_q    <= pwdata[10:0];
				REG_SCALE_PERCENT: scale_percent_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer
	always_comb begin
		unique case (reg_idx)
			REG_SPEED_ID_A:    prdata = {21'd0, speed_id_a_q};
			REG_SPEED_ID_B:    prdata = {21'd0, speed_id_b_q};
			REG_SCALE_PERCENT: prdata = {24'd0, scale_percent_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.speed_id_a    = speed_id_a_q;
	assign cfg.speed_id_b    = speed_id_b_q;
	assign cfg.scale_percent = scale_percent_q;
endmodule

// ===== rtl/csrg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN speed rescale gateway datapath
// Six-stage pipeline: match and decode, scale, divide by 100, divide by 200,
// remainder and saturation, re-encode into the output register.
// ----------------------------------------------------------------------------
module csrg_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  csrg_pkg::cfg_t cfg,
	csrg_in_if.sink        frame_in,
	csrg_out_if.source     frame_out
);
	import csrg_pkg::*;

	logic adv;

	// Stage 1: identifier match and speed decode
	logic        v_s1;
	logic        op_s1;
	logic        rew_s1;
	logic [10:0] id_s1;
	logic [63:0] pl_s1;
	logic [15:0] speed_s1;
	logic        id_hit;
	logic [15:0] hi_units;
	logic [14:0] lo_prod;
	logic [15:0] speed_d;

	// Stage 2 to stage 6 registers
	logic        v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        op_s2, op_s3, op_s4, op_s5, op_s6;
	logic        rew_s2, rew_s3, rew_s4, rew_s5, rew_s6;
	logic [10:0] id_s2, id_s3, id_s4, id_s5, id_s6;
	logic [63:0] pl_s2, pl_s3, pl_s4, pl_s5, pl_s6;
	logic [23:0] prod_s2;
	logic [16:0] scl_s3;
	logic [48:0] scl_full;
	logic        sat_s4;
	logic [15:0] scl_s4;
	logic [7:0]  q_s4;
	logic [32:0] q_full;
	logic [7:0]  q_s5;
	logic [7:0]  r_s5;
	logic [15:0] q_units;
	logic [15:0] r_wide;
	logic [14:0] r_shift;
	logic [30:0] b1_full;
	logic [7:0]  nb1;

	// The whole pipeline moves unless the output register holds an untaken item
	assign adv            = !v_s6 || frame_out.ready;
	assign frame_in.ready = adv;

	assign id_hit   = (frame_in.frame_id == cfg.speed_id_a) ||
		(frame_in.frame_id == cfg.speed_id_b);
	assign hi_units = 16'(frame_in.payload[7:0]) * 16'(STEP_UNITS);
	assign lo_prod  = 15'(frame_in.payload[15:8]) * 15'(PCT_DEN);
	assign speed_d  = hi_units + {8'd0, lo_prod[14:7]};

	// Arithmetic for stages 3 to 6
	assign scl_full = 49'(prod_s2) * 49'(RECIP_100_31);
	assign q_full   = 33'(scl_s3[15:0]) * 33'(RECIP_200_24);
	assign q_units  = 16'(q_s4) * 16'(STEP_UNITS);
	assign r_wide   = scl_s4 - q_units;
	assign r_shift  = {r_s5, 7'd0};
	assign b1_full  = 31'(r_shift) * 31'(RECIP_100_22);
	assign nb1      = b1_full[29:22];

	// Valid bits; items without transmit space are dropped at entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= frame_in.valid && frame_in.tx_space;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Payload registers of all stages
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= frame_in.op;
			rew_s1   <= frame_in.op && id_hit;
			id_s1    <= frame_in.frame_id;
			pl_s1    <= frame_in.payload;
			speed_s1 <= speed_d;

			op_s2   <= op_s1;
			rew_s2  <= rew_s1;
			id_s2   <= id_s1;
			pl_s2   <= pl_s1;
			prod_s2 <= 24'(speed_s1) * 24'(cfg.scale_percent);

			op_s3  <= op_s2;
			rew_s3 <= rew_s2;
			id_s3  <= id_s2;
			pl_s3  <= pl_s2;
			scl_s3 <= scl_full[47:31];

			op_s4  <= op_s3;
			rew_s4 <= rew_s3;
			id_s4  <= id_s3;
			pl_s4  <= pl_s3;
			sat_s4 <= scl_s3 >= SAT_LIMIT;
			scl_s4 <= scl_s3[15:0];
			q_s4   <= q_full[31:24];

			op_s5  <= op_s4;
			rew_s5 <= rew_s4;
			id_s5  <= id_s4;
			pl_s5  <= pl_s4;
			q_s5   <= sat_s4 ? Q_SAT : q_s4;
			r_s5   <= sat_s4 ? R_SAT : r_wide[7:0];

			op_s6  <= op_s5;
			rew_s6 <= rew_s5;
			id_s6  <= id_s5;
			pl_s6  <= rew_s5 ? {pl_s5[63:16], nb1, q_s5} : pl_s5;
		end
	end

	// Output register drives the forwarded frame channel
	assign frame_out.valid         = v_s6;
	assign frame_out.dest_bus      = op_s6;
	assign frame_out.out_id        = id_s6;
	assign frame_out.out_payload   = pl_s6;
	assign frame_out.watchdog_kick = !op_s6 || rew_s6;
endmodule

// ===== rtl/can_speed_rescale_gateway.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN speed rescale gateway
// Forwards received CAN frames between the dashboard and vehicle buses and
// rescales the speed bytes of vehicle-side speed frames.
// ----------------------------------------------------------------------------
// Usage:
// Each item on frame_in is one received standard frame with its source side
// and the transmit space flag of the destination. An item with tx_space low
// is accepted and dropped. Every other item leaves on frame_out as one
// forwarded frame, in arrival order.
// The pipeline accepts one item per cycle while frame_out does not stall;
// the six stages are decode, scale multiply, divide by 100, divide by 200,
// remainder and saturation, re-encode. When frame_out stalls, the whole
// pipeline holds and frame_in.ready falls only while the output register
// carries an item that is not yet taken. Reset clears all valid bits and
// loads the register defaults (speed IDs 0x214 and 0x215, scale 110
// percent). Registers are at byte addresses 0, 4 and 8; the user must
// write them only while the pipeline is empty, as the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
module can_speed_rescale_gateway (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	csrg_in_if.sink     frame_in,
	csrg_out_if.source  frame_out
);
	import csrg_pkg::*;

	cfg_t cfg;

	// Configuration registers
	csrg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Forwarding and rescaling pipeline
	csrg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.frame_in  (frame_in),
		.frame_out (frame_out)
	);
endmodule
